>>> design/pmq_pkg.sv
// Shared constants, types and the square-root step for the pose matrix to quaternion block.
`default_nettype none
package pmq_pkg;

	localparam int ROT_FRAC_BITS = 14;
	localparam int COEF_W = 16;
	localparam int POS_W = 32;
	localparam int QW_W = 15;
	localparam int QV_OUT_W = 16;

	// Signed width that holds one plus or minus three rotation entries.
	localparam int RAD_W = ((ROT_FRAC_BITS > COEF_W) ? ROT_FRAC_BITS : COEF_W) + 3;
	localparam int RADU_W = RAD_W - 1;
	localparam int SQN_W0 = RADU_W + ROT_FRAC_BITS;
	localparam int SQN_W = SQN_W0 + (SQN_W0 % 2);
	localparam int ROOT_W = SQN_W / 2;
	localparam int REM_W = ROOT_W + 1;
	localparam int QV_W = (ROOT_W > QV_OUT_W) ? ROOT_W : QV_OUT_W;
	// Front stage, one stage per root bit, output stage.
	localparam int NSTG = ROOT_W + 2;

	localparam logic signed [RAD_W-1:0] RAD_ONE = RAD_W'(1) << ROT_FRAC_BITS;
	localparam logic [ROOT_W-1:0] MAG_ONE = ROOT_W'(1) << ROT_FRAC_BITS;

	typedef logic [3:0][RADU_W-1:0] rad_vec_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [2:0] neg;
	} side_t;

	typedef struct packed {
		logic [SQN_W-1:0] n;
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// One bit of a restoring integer square root, most significant operand bits first.
	function automatic sq_t sq_step(input sq_t s);
		sq_t o;
		logic [REM_W+1:0] t;
		logic [REM_W+1:0] trial;
		t = {s.rem, s.n[SQN_W-1 -: 2]};
		trial = (REM_W + 2)'({s.root, 2'b01});
		o.n = s.n << 2;
		if (t >= trial) begin
			o.rem = REM_W'(t - trial);
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem = REM_W'(t);
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage
`default_nettype wire

>>> design/pmq_ctrl.sv
// Valid bits and stage enables of the pipeline, with bubble collapsing.
`default_nettype none
module pmq_ctrl import pmq_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [NSTG-1:0]      en
);

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0] rdy;

	// A stage may load when it is empty or when the stage after it moves on.
	assign rdy[NSTG] = !out_stall;
	for (genvar i = 0; i < NSTG; i++) begin : g_rdy
		assign rdy[i] = !vld_q[i] || rdy[i+1];
	end

	assign en = rdy[NSTG-1:0];
	assign in_stall = !rdy[0];
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[NSTG-2:0], in_valid}) | (~en & vld_q);
		end
	end

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled while the pipeline has a bubble");

	a_hold_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		((~en & ~vld_q) == '0))
		else $error("an empty stage is held");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted transfer did not enter the first stage");

	a_out_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !vld_q[NSTG-2]) |=> !out_valid)
		else $error("output stage kept a delivered item");

endmodule
`default_nettype wire

>>> design/pmq_front.sv
// First stage: radicands with clamping, sign bits and the translation column.
`default_nettype none
module pmq_front import pmq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [COEF_W-1:0] r00,
	input  wire logic signed [COEF_W-1:0] r01,
	input  wire logic signed [COEF_W-1:0] r02,
	input  wire logic signed [COEF_W-1:0] r10,
	input  wire logic signed [COEF_W-1:0] r11,
	input  wire logic signed [COEF_W-1:0] r12,
	input  wire logic signed [COEF_W-1:0] r20,
	input  wire logic signed [COEF_W-1:0] r21,
	input  wire logic signed [COEF_W-1:0] r22,
	input  wire logic signed [POS_W-1:0]  tx,
	input  wire logic signed [POS_W-1:0]  ty,
	input  wire logic signed [POS_W-1:0]  tz,
	output rad_vec_t                     rad_s1,
	output side_t                        side_s1
);

	logic signed [RAD_W-1:0] e00, e11, e22;
	logic signed [RAD_W-1:0] rad_c [4];
	logic signed [COEF_W:0] dx, dy, dz;
	rad_vec_t radu_c;

	always_comb begin
		e00 = RAD_W'(r00);
		e11 = RAD_W'(r11);
		e22 = RAD_W'(r22);
		rad_c[0] = RAD_ONE + e00 + e11 + e22;
		rad_c[1] = RAD_ONE + e00 - e11 - e22;
		rad_c[2] = RAD_ONE - e00 + e11 - e22;
		rad_c[3] = RAD_ONE - e00 - e11 + e22;
		// A negative radicand gives a zero magnitude.
		for (int i = 0; i < 4; i++) begin
			radu_c[i] = rad_c[i][RAD_W-1] ? '0 : rad_c[i][RADU_W-1:0];
		end
		dx = (COEF_W + 1)'(r21) - (COEF_W + 1)'(r12);
		dy = (COEF_W + 1)'(r02) - (COEF_W + 1)'(r20);
		dz = (COEF_W + 1)'(r10) - (COEF_W + 1)'(r01);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= radu_c;
			side_s1.pos_x <= tx;
			side_s1.pos_y <= ty;
			side_s1.pos_z <= tz;
			side_s1.neg <= {dz[COEF_W], dy[COEF_W], dx[COEF_W]};
		end
	end

endmodule
`default_nettype wire

>>> design/pmq_isqrt.sv
// Pipelined integer square root of a radicand scaled by the fraction bits, one root bit a stage.
`default_nettype none
module pmq_isqrt import pmq_pkg::*; (
	input  wire logic              clk,
	input  wire logic [ROOT_W-1:0] en,
	input  wire logic [RADU_W-1:0] rad,
	output logic [ROOT_W-1:0]      root
);

	sq_t init;
	sq_t sq_sn [ROOT_W];

	always_comb begin
		init.n = SQN_W'(rad) << ROT_FRAC_BITS;
		init.rem = '0;
		init.root = '0;
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					sq_sn[k] <= sq_step(init);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k]) begin
					sq_sn[k] <= sq_step(sq_sn[k-1]);
				end
			end
		end
	end

	assign root = sq_sn[ROOT_W-1].root;

endmodule
`default_nettype wire

>>> design/pose_matrix_to_quaternion.sv
// Top level: pose matrix in, position and unit quaternion out, fully pipelined.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------------
//   input   | in_valid, in_stall  | r00..r22 (s16, 1.0 = 16384), tx ty tz (s32)
//   output  | out_valid, out_stall| pos_x pos_y pos_z (s32), quat_w (u15),
//           |                     | quat_x quat_y quat_z (s16)
//
// One item per cycle while the output is not stalled; the stages are:
// a radicand stage, one stage per square-root bit, and the output register.
// Reset clears only the valid bits; no clearing pass is needed.
// A stall on the output holds the output register; stages behind it keep filling
// empty slots, so in_stall rises only once every stage holds an item.
`default_nettype none
module pose_matrix_to_quaternion import pmq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [COEF_W-1:0] r00,
	input  wire logic signed [COEF_W-1:0] r01,
	input  wire logic signed [COEF_W-1:0] r02,
	input  wire logic signed [COEF_W-1:0] r10,
	input  wire logic signed [COEF_W-1:0] r11,
	input  wire logic signed [COEF_W-1:0] r12,
	input  wire logic signed [COEF_W-1:0] r20,
	input  wire logic signed [COEF_W-1:0] r21,
	input  wire logic signed [COEF_W-1:0] r22,
	input  wire logic signed [POS_W-1:0]  tx,
	input  wire logic signed [POS_W-1:0]  ty,
	input  wire logic signed [POS_W-1:0]  tz,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [POS_W-1:0]      pos_x,
	output logic signed [POS_W-1:0]      pos_y,
	output logic signed [POS_W-1:0]      pos_z,
	output logic [QW_W-1:0]              quat_w,
	output logic signed [QV_OUT_W-1:0]   quat_x,
	output logic signed [QV_OUT_W-1:0]   quat_y,
	output logic signed [QV_OUT_W-1:0]   quat_z
);

	logic [NSTG-1:0] en;
	rad_vec_t rad_s1;
	side_t side_s1;
	side_t side_sn [ROOT_W];
	logic [3:0][ROOT_W-1:0] root;
	logic [3:0][QV_W-1:0] mag_c;
	logic [2:0][QV_W-1:0] sgn_c;

	pmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	pmq_front u_front (
		.clk     (clk),
		.en      (en[0]),
		.r00     (r00),
		.r01     (r01),
		.r02     (r02),
		.r10     (r10),
		.r11     (r11),
		.r12     (r12),
		.r20     (r20),
		.r21     (r21),
		.r22     (r22),
		.tx      (tx),
		.ty      (ty),
		.tz      (tz),
		.rad_s1  (rad_s1),
		.side_s1 (side_s1)
	);

	for (genvar c = 0; c < 4; c++) begin : g_root
		pmq_isqrt u_isqrt (
			.clk  (clk),
			.en   (en[ROOT_W:1]),
			.rad  (rad_s1[c]),
			.root (root[c])
		);
	end

	// Position and sign bits ride alongside the root stages.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k+1]) begin
					side_sn[k] <= side_s1;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k+1]) begin
					side_sn[k] <= side_sn[k-1];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			// Halve the root and saturate at one.
			mag_c[c] = QV_W'(((root[c] >> 1) > MAG_ONE) ? MAG_ONE : (root[c] >> 1));
		end
		for (int c = 0; c < 3; c++) begin
			sgn_c[c] = side_sn[ROOT_W-1].neg[c] ? (QV_W'(0) - mag_c[c+1]) : mag_c[c+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			pos_x  <= side_sn[ROOT_W-1].pos_x;
			pos_y  <= side_sn[ROOT_W-1].pos_y;
			pos_z  <= side_sn[ROOT_W-1].pos_z;
			quat_w <= mag_c[0][QW_W-1:0];
			quat_x <= sgn_c[0][QV_OUT_W-1:0];
			quat_y <= sgn_c[1][QV_OUT_W-1:0];
			quat_z <= sgn_c[2][QV_OUT_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> tb/tb_pose_matrix_to_quaternion.sv
// Self-checking testbench for the pose matrix to quaternion pipeline.
`timescale 1ns / 1ps
module tb_pose_matrix_to_quaternion;
	import pmq_pkg::*;

	typedef struct packed {
		logic signed [COEF_W-1:0] r00;
		logic signed [COEF_W-1:0] r01;
		logic signed [COEF_W-1:0] r02;
		logic signed [COEF_W-1:0] r10;
		logic signed [COEF_W-1:0] r11;
		logic signed [COEF_W-1:0] r12;
		logic signed [COEF_W-1:0] r20;
		logic signed [COEF_W-1:0] r21;
		logic signed [COEF_W-1:0] r22;
		logic signed [POS_W-1:0] tx;
		logic signed [POS_W-1:0] ty;
		logic signed [POS_W-1:0] tz;
	} matrix_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [QW_W-1:0] quat_w;
		logic signed [QV_OUT_W-1:0] quat_x;
		logic signed [QV_OUT_W-1:0] quat_y;
		logic signed [QV_OUT_W-1:0] quat_z;
	} pose_t;

	class pose_scoreboard;
		pose_t awaited[$];
		int unsigned mismatches = 0;

		// Half the square root of rad / 1.0, truncated, zero for a nonpositive radicand,
		// and saturated to 1.0.
		function longint half_root(longint rad);
			longint unsigned n;
			longint unsigned r;
			longint unsigned c;
			if (rad <= 0)
				return 0;
			n = longint'(rad) << ROT_FRAC_BITS;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (c * c <= n)
					r = c;
			end
			r = r >> 1;
			return (r > (64'd1 << ROT_FRAC_BITS)) ? (longint'(1) << ROT_FRAC_BITS) : longint'(r);
		endfunction

		function pose_t pose_from_matrix(matrix_t m);
			longint unity = longint'(1) << ROT_FRAC_BITS;
			longint a00 = m.r00;
			longint a01 = m.r01;
			longint a02 = m.r02;
			longint a10 = m.r10;
			longint a11 = m.r11;
			longint a12 = m.r12;
			longint a20 = m.r20;
			longint a21 = m.r21;
			longint a22 = m.r22;
			longint mag;
			pose_t p;
			p.pos_x = m.tx;
			p.pos_y = m.ty;
			p.pos_z = m.tz;
			p.quat_w = QW_W'(half_root(unity + a00 + a11 + a22));
			// A zero off-diagonal difference keeps the component positive.
			mag = half_root(unity + a00 - a11 - a22);
			p.quat_x = (a21 - a12 < 0) ? QV_OUT_W'(-mag) : QV_OUT_W'(mag);
			mag = half_root(unity - a00 + a11 - a22);
			p.quat_y = (a02 - a20 < 0) ? QV_OUT_W'(-mag) : QV_OUT_W'(mag);
			mag = half_root(unity - a00 - a11 + a22);
			p.quat_z = (a10 - a01 < 0) ? QV_OUT_W'(-mag) : QV_OUT_W'(mag);
			return p;
		endfunction

		function void note_matrix(matrix_t m);
			awaited.insert(awaited.size(), pose_from_matrix(m));
		endfunction

		function void compare_field(string name, longint want, longint seen);
			if (want != seen) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, seen);
				mismatches++;
			end
		endfunction

		function void check_pose(pose_t seen);
			pose_t want;
			if (awaited.size() == 0) begin
				$error("pose transfer with no pending matrix");
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			compare_field("pos_x", want.pos_x, seen.pos_x);
			compare_field("pos_y", want.pos_y, seen.pos_y);
			compare_field("pos_z", want.pos_z, seen.pos_z);
			compare_field("quat_w", want.quat_w, seen.quat_w);
			compare_field("quat_x", want.quat_x, seen.quat_x);
			compare_field("quat_y", want.quat_y, seen.quat_y);
			compare_field("quat_z", want.quat_z, seen.quat_z);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [COEF_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [POS_W-1:0] tx, ty, tz;
	logic out_valid;
	logic out_stall;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [QW_W-1:0] quat_w;
	logic signed [QV_OUT_W-1:0] quat_x, quat_y, quat_z;

	pose_scoreboard board = new;
	bit quiet_tail = 0;
	bit calm_stretch = 0;
	matrix_t item;
	int e[9];
	int sel;
	real qa, qb, qc, qd, nrm;
	int corner_coef[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
	logic [POS_W-1:0] corner_pos[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

	pose_matrix_to_quaternion dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.r00(r00), .r01(r01), .r02(r02),
		.r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.tx(tx), .ty(ty), .tz(tz),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_matrix('{r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz});
		if (arst_n && out_valid && !out_stall)
			board.check_pose('{pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z});
	end

	function automatic matrix_t rotation_item(int a00, int a01, int a02, int a10, int a11,
			int a12, int a20, int a21, int a22);
		matrix_t m;
		m.r00 = COEF_W'(a00);
		m.r01 = COEF_W'(a01);
		m.r02 = COEF_W'(a02);
		m.r10 = COEF_W'(a10);
		m.r11 = COEF_W'(a11);
		m.r12 = COEF_W'(a12);
		m.r20 = COEF_W'(a20);
		m.r21 = COEF_W'(a21);
		m.r22 = COEF_W'(a22);
		m.tx = $urandom;
		m.ty = $urandom;
		m.tz = $urandom;
		return m;
	endfunction

	// An optional idle burst, then one matrix held until its transfer.
	task automatic send_matrix(input matrix_t m);
		int gap;
		if (!quiet_tail && !calm_stretch && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		{r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz} <= m;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			if (quiet_tail || !arst_n) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 13);
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				n = $urandom_range(1, 40);
				@(negedge clk);
				out_stall <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		{r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz} = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Identity: w lands exactly on 1.0.
		send_matrix(rotation_item(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
		send_matrix(rotation_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
		item = rotation_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		item.tx = 32'h7fff_ffff;
		item.ty = 32'h7fff_ffff;
		item.tz = 32'h7fff_ffff;
		send_matrix(item);
		item = rotation_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768);
		item.tx = 32'h8000_0000;
		item.ty = 32'h8000_0000;
		item.tz = 32'h8000_0000;
		send_matrix(item);
		// Half turns about each axis leave w at a zero radicand.
		send_matrix(rotation_item(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
		send_matrix(rotation_item(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
		send_matrix(rotation_item(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
		// Quarter turns in both directions exercise each sign.
		send_matrix(rotation_item(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
		send_matrix(rotation_item(16384, 0, 0, 0, 0, 16384, 0, -16384, 0));
		send_matrix(rotation_item(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
		send_matrix(rotation_item(0, 0, -16384, 0, 16384, 0, 16384, 0, 0));
		send_matrix(rotation_item(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
		send_matrix(rotation_item(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
		// Strongly negative diagonal clamps w; a large positive one saturates it.
		send_matrix(rotation_item(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
		send_matrix(rotation_item(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
		send_matrix(rotation_item(16385, 0, 0, 0, 16385, 0, 0, 0, 16385));
		// Largest off-diagonal differences of either sign.
		send_matrix(rotation_item(0, 32767, 32767, -32768, 0, 32767, -32768, -32768, 0));
		send_matrix(rotation_item(0, -32768, -32768, 32767, 0, -32768, 32767, 32767, 0));
		// Equal off-diagonal pairs give a zero difference and a positive sign.
		send_matrix(rotation_item(-4096, 32767, -7000, 32767, -4096, 5000, -7000, 5000, -4096));
		// Radicand of exactly one.
		send_matrix(rotation_item(-16383, 0, 0, 0, 0, 0, 0, 0, 0));
		item = rotation_item(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
		item.tx = 32'h5555_5555;
		item.ty = 32'haaaa_aaaa;
		item.tz = 32'h5555_5555;
		send_matrix(item);
		item.tx = 32'haaaa_aaaa;
		item.ty = 32'h5555_5555;
		item.tz = 32'haaaa_aaaa;
		send_matrix(item);

		for (int i = 0; i < 450; i++) begin
			if (i % 32 == 0)
				calm_stretch = ($urandom_range(0, 2) == 0);
			quiet_tail = (i >= 390);
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				// Near-rotation from a random quaternion, with a little noise.
				qa = real'($urandom_range(0, 2000)) - 1000.0;
				qb = real'($urandom_range(0, 2000)) - 1000.0;
				qc = real'($urandom_range(0, 2000)) - 1000.0;
				qd = real'($urandom_range(0, 2000)) - 1000.0;
				nrm = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd);
				if (nrm < 1.0) begin
					qa = 1.0;
					nrm = 1.0;
				end
				qa = qa / nrm;
				qb = qb / nrm;
				qc = qc / nrm;
				qd = qd / nrm;
				e[0] = $rtoi(16384.0 * (1.0 - 2.0 * (qc * qc + qd * qd)));
				e[1] = $rtoi(32768.0 * (qb * qc - qd * qa));
				e[2] = $rtoi(32768.0 * (qb * qd + qc * qa));
				e[3] = $rtoi(32768.0 * (qb * qc + qd * qa));
				e[4] = $rtoi(16384.0 * (1.0 - 2.0 * (qb * qb + qd * qd)));
				e[5] = $rtoi(32768.0 * (qc * qd - qb * qa));
				e[6] = $rtoi(32768.0 * (qb * qd - qc * qa));
				e[7] = $rtoi(32768.0 * (qc * qd + qb * qa));
				e[8] = $rtoi(16384.0 * (1.0 - 2.0 * (qb * qb + qc * qc)));
				foreach (e[k])
					e[k] = e[k] + int'($urandom_range(0, 16)) - 8;
			end else if (sel < 75) begin
				foreach (e[k])
					e[k] = int'($urandom_range(0, 65535)) - 32768;
			end else if (sel < 90) begin
				foreach (e[k])
					e[k] = int'($urandom_range(0, 32768)) - 16384;
			end else begin
				foreach (e[k])
					e[k] = corner_coef[$urandom_range(0, 6)];
				if ($urandom_range(0, 1) == 1)
					e[5] = e[7];
				if ($urandom_range(0, 1) == 1)
					e[2] = e[6];
				if ($urandom_range(0, 1) == 1)
					e[1] = e[3];
			end
			item = rotation_item(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
			if ($urandom_range(0, 99) < 15) begin
				item.tx = corner_pos[$urandom_range(0, 3)];
				item.ty = corner_pos[$urandom_range(0, 3)];
				item.tz = corner_pos[$urandom_range(0, 3)];
			end
			send_matrix(item);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		// Any late extra pose transfer would be flagged by the scoreboard here.
		repeat (NSTG + 8) @(posedge clk);
		if (board.mismatches == 0 && board.awaited.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
design/pmq_pkg.sv
design/pmq_ctrl.sv
design/pmq_front.sv
design/pmq_isqrt.sv
design/pose_matrix_to_quaternion.sv
tb/tb_pose_matrix_to_quaternion.sv
